// ===== rtl/core/svenc_pkg.sv =====
package svenc_pkg;

    localparam int ValueWidth = 64;
    localparam int ByteWidth  = 8;
    localparam int GroupWidth = 7;
    localparam int HeadWidth  = 6;
    localparam int MaxBytes   = 10;
    localparam int ShWidth    = HeadWidth + GroupWidth * (MaxBytes - 1) + 1;
    localparam int CntWidth   = $clog2(MaxBytes + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_NORM = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    typedef struct packed {
        logic                  first;
        logic                  neg;
        logic                  last;
        logic [ShWidth-1:0]    sh;
    } group_req_t;

    typedef struct packed {
        logic                  top_zero;
        logic [ByteWidth-1:0]  data;
        logic [ShWidth-1:0]    shifted;
    } group_rsp_t;

endpackage

// ===== rtl/core/svenc_group_unit.sv =====
module svenc_group_unit
    import svenc_pkg::*;
(
    input  group_req_t req,
    output group_rsp_t rsp
);

    logic [GroupWidth-1:0] payload;

    always_comb begin
        if (req.first) begin
            payload = {req.neg, req.sh[ShWidth-2 -: HeadWidth]};
        end else begin
            payload = req.sh[ShWidth-1 -: GroupWidth];
        end
        // top group plus the next bit must be clear to drop one byte
        rsp.top_zero = (req.sh[ShWidth-2 -: GroupWidth] == '0);
        rsp.data     = {~req.last, payload};
        rsp.shifted  = {req.sh[ShWidth-GroupWidth-1:0], {GroupWidth{1'b0}}};
    end

endmodule

// ===== rtl/core/signed_varint_encoder_unit.sv =====
// one byte per cycle while emitting and not stalled; a new value waits for the last byte
// the normalize loop drops one leading 7-bit group per cycle through the shared group unit
// s_ready is high only while the sequencer is idle
// synchronous active-low reset clears the sequencer and the output valid
module signed_varint_encoder_unit
    import svenc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ValueWidth-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ByteWidth-1:0]  m_out_byte,
    output logic                  m_last
);

    logic [1:0]           state_reg, state_next;
    logic [CntWidth-1:0]  cnt_reg, cnt_next;
    logic [ShWidth-1:0]   sh_reg, sh_next;
    logic                 neg_reg, neg_next;
    logic                 first_reg, first_next;
    logic                 m_valid_reg, m_valid_next;
    logic [ByteWidth-1:0] m_out_byte_reg, m_out_byte_next;
    logic                 m_last_reg, m_last_next;

    logic                 in_fire;
    logic                 emit_fire;
    logic [ValueWidth-1:0] mag;
    group_req_t           greq;
    group_rsp_t           grsp;

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_fire    = s_valid && s_ready;
    assign emit_fire  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_last     = m_last_reg;

    assign mag = s_value[ValueWidth-1] ? (~s_value + 1'b1) : s_value;

    assign greq.first = first_reg;
    assign greq.neg   = neg_reg;
    assign greq.last  = (cnt_reg == CntWidth'(1));
    assign greq.sh    = sh_reg;

    svenc_group_unit u_group (
        .req (greq),
        .rsp (grsp)
    );

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        sh_next         = sh_reg;
        neg_next        = neg_reg;
        first_next      = first_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_out_byte_next = m_out_byte_reg;
        m_last_next     = m_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    sh_next    = {{(ShWidth-ValueWidth){1'b0}}, mag};
                    neg_next   = s_value[ValueWidth-1];
                    cnt_next   = CntWidth'(MaxBytes);
                    first_next = 1'b1;
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                if ((cnt_reg != CntWidth'(1)) && grsp.top_zero) begin
                    sh_next  = grsp.shifted;
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    m_valid_next    = 1'b1;
                    m_out_byte_next = grsp.data;
                    m_last_next     = greq.last;
                    sh_next         = grsp.shifted;
                    cnt_next        = cnt_reg - 1'b1;
                    first_next      = 1'b0;
                    if (greq.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg         <= sh_next;
        neg_reg        <= neg_next;
        first_reg      <= first_next;
        m_out_byte_reg <= m_out_byte_next;
        m_last_reg     <= m_last_next;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (cnt_reg != '0 && cnt_reg <= CntWidth'(MaxBytes)))
        else $error("byte count out of range while busy");

    a_accept_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_NORM && cnt_reg == CntWidth'(MaxBytes)))
        else $error("accepted value did not start normalize");

    a_sign_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && first_reg && neg_reg) |=> (m_valid && m_out_byte[ByteWidth-2]))
        else $error("sign bit missing on first byte of negative value");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && cnt_reg == CntWidth'(1)) |=> (state_reg == ST_IDLE && m_last))
        else $error("final byte did not end the encoding");
`endif

endmodule
